// ===== sv/crcb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, widths and handshake structs of the count rate unit
// no dependencies
package crcb_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int SQRT_FRAC_BITS = 16;

    localparam int PULSE_W   = 24;
    localparam int SECS_W    = 32;
    localparam int SCALE_W   = 16;
    localparam int MINT_W    = 16;
    localparam int SIGMA_W   = 4;
    localparam int RATE_W    = 40;
    localparam int HIGH_W    = 41;
    localparam int HOURS_W   = 21;
    localparam int MINUTES_W = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEASURE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_MULTIPLIER = 2'd2;

    localparam logic [SCALE_W-1:0] RST_VOLUME_SCALE     = 16'd2598;
    localparam logic [MINT_W-1:0]  RST_MIN_MEASURE_TIME = 16'd60;
    localparam logic [SIGMA_W-1:0] RST_SIGMA_MULTIPLIER = 4'd2;

    localparam int SECS_PER_MIN  = 60;
    localparam int MIN_PER_HOUR  = 60;

    // root of count * 2^(2*frac): one result bit per bit pair
    localparam int SQRT_PAIRS  = (COUNT_BITS + 1) / 2 + SQRT_FRAC_BITS;
    localparam int ROOT_W      = SQRT_PAIRS;
    localparam int SQRT_SRC_W  = 2 * SQRT_PAIRS;
    localparam int SQRT_REM_W  = ROOT_W + 2;
    localparam int SQRT_CNT_W  = $clog2(SQRT_PAIRS + 1);

    // shared divider: scale * root is the widest dividend
    localparam int NUM_W      = SCALE_W + ROOT_W;
    localparam int DEN_W      = SECS_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam int ERR_W = NUM_W - SQRT_FRAC_BITS;
    localparam int MRG_W = SIGMA_W + ERR_W;
    localparam int BND_W = (NUM_W + 1 > HIGH_W) ? NUM_W + 1 : HIGH_W;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [HIGH_W-1:0] HIGH_MAX = '1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] count;
    } t_sqrt_req;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

// ===== sv/crcb_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels of the count rate unit: input beat and result beat
// depends on crcb_pkg
interface crcb_in_if import crcb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_count;
    logic [SECS_W-1:0]  measure_seconds;
    logic [SECS_W-1:0]  total_seconds;

    modport source (output valid, pulse_count, measure_seconds, total_seconds, input ready);
    modport sink   (input valid, pulse_count, measure_seconds, total_seconds, output ready);
endinterface

interface crcb_out_if import crcb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RATE_W-1:0]    rate;
    logic [RATE_W-1:0]    rate_low;
    logic [HIGH_W-1:0]    rate_high;
    logic [HOURS_W-1:0]   run_hours;
    logic [MINUTES_W-1:0] run_minutes;
    logic                 fresh;

    modport source (output valid, rate, rate_low, rate_high, run_hours, run_minutes, fresh,
                    input ready);
    modport sink   (input valid, rate, rate_low, rate_high, run_hours, run_minutes, fresh,
                    output ready);
endinterface

// ===== sv/crcb_div.sv =====
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on crcb_pkg
module crcb_div import crcb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with exhausted bit count");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_den != '0 |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

endmodule

// ===== sv/crcb_sqrt.sv =====
`timescale 1ns / 1ps
// digit-by-digit square root of the scaled count, one bit pair per cycle
// depends on crcb_pkg
module crcb_sqrt import crcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic                  r_busy;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic [SQRT_SRC_W-1:0] r_src;
    logic [SQRT_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]     r_root;

    logic [SQRT_REM_W-1:0] w_shift;
    logic [SQRT_REM_W-1:0] w_trial;
    logic                  w_ge;

    assign w_shift = {r_rem[SQRT_REM_W-3:0], r_src[SQRT_SRC_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_shift >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQRT_CNT_W'(SQRT_PAIRS);
                r_src  <= SQRT_SRC_W'(i_req.count) << (2 * SQRT_FRAC_BITS);
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_src  <= {r_src[SQRT_SRC_W-3:0], 2'b00};
                r_rem  <= w_ge ? w_shift - w_trial : w_shift;
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == SQRT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.root = r_root;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_rem <= {1'b0, r_root, 1'b0})
        else $error("root remainder above twice the root");

endmodule

// ===== sv/count_rate_with_confidence_bounds_unit.sv =====
`timescale 1ns / 1ps
// count rate with confidence bounds: sequencer, bound logic and result register
// depends on crcb_pkg, crcb_if, crcb_div, crcb_sqrt
//
// One beat in gives one beat out. Run hours and minutes come from two divisions
// by 60; once the measuring time reaches the minimum, the rate and its error
// come from two more divisions by the measuring time, while the root of the
// count runs alongside. All four divisions use one serial divider, one quotient
// bit per cycle. The input is not ready while a beat is worked on; a finished
// result waits in the output register while the next beat is taken, and a beat
// that finishes while that register is still full waits until it drains.
module count_rate_with_confidence_bounds_unit import crcb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    crcb_in_if.sink               i_in,
    crcb_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIN  = 3'd1;
    localparam logic [2:0] S_HR   = 3'd2;
    localparam logic [2:0] S_RATE = 3'd3;
    localparam logic [2:0] S_SQW  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;
    localparam logic [2:0] S_BND  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;

    logic [SCALE_W-1:0] r_cfg_scale;
    logic [MINT_W-1:0]  r_cfg_min;
    logic [SIGMA_W-1:0] r_cfg_sigma;

    logic [COUNT_BITS-1:0] r_count;
    logic [SECS_W-1:0]     r_secs;
    logic                  r_go;
    logic [HOURS_W-1:0]    r_hours;
    logic [MINUTES_W-1:0]  r_minutes;
    logic [NUM_W-1:0]      r_rate;
    logic [MRG_W-1:0]      r_margin;

    logic [RATE_W-1:0] r_held_rate;
    logic [RATE_W-1:0] r_held_low;
    logic [HIGH_W-1:0] r_held_high;

    logic                 r_div_start;
    logic [NUM_W-1:0]     r_div_num;
    logic [DEN_W-1:0]     r_div_den;
    logic                 r_sqrt_start;

    logic                 r_out_valid;
    logic [RATE_W-1:0]    r_out_rate;
    logic [RATE_W-1:0]    r_out_low;
    logic [HIGH_W-1:0]    r_out_high;
    logic [HOURS_W-1:0]   r_out_hours;
    logic [MINUTES_W-1:0] r_out_minutes;
    logic                 r_out_fresh;

    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;
    t_sqrt_req w_sqrt_req;
    t_sqrt_rsp w_sqrt_rsp;

    logic             w_in_acc;
    logic             w_go;
    logic             w_sqrt_idle;
    logic             w_div_go;
    logic             w_out_load;
    logic [BND_W-1:0] w_rate_x;
    logic [BND_W-1:0] w_mrg_x;
    logic [BND_W-1:0] w_lo;
    logic [BND_W-1:0] w_hi;
    logic [RATE_W-1:0] w_rate_sat;
    logic [RATE_W-1:0] w_lo_sat;
    logic [HIGH_W-1:0] w_hi_sat;

    assign w_div_req.start = r_div_start;
    assign w_div_req.num   = r_div_num;
    assign w_div_req.den   = r_div_den;

    assign w_sqrt_req.start = r_sqrt_start;
    assign w_sqrt_req.count = r_count;

    crcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    crcb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sqrt_req),
        .o_rsp   (w_sqrt_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_go       = (i_in.measure_seconds != '0)
                        && (i_in.measure_seconds >= SECS_W'(r_cfg_min));

    // divider starts: minutes, hours, rate, error
    assign w_sqrt_idle = !w_sqrt_rsp.busy && !r_sqrt_start;
    assign w_div_go    = w_in_acc
                         || ((r_state == S_MIN) && w_div_rsp.done)
                         || ((r_state == S_HR) && w_div_rsp.done && r_go)
                         || ((r_state == S_SQW) && w_sqrt_idle);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // bounds from the unsaturated rate, each saturated to its own width
    assign w_rate_x   = BND_W'(r_rate);
    assign w_mrg_x    = BND_W'(r_margin);
    assign w_lo       = (w_mrg_x <= w_rate_x) ? w_rate_x - w_mrg_x : '0;
    assign w_hi       = w_rate_x + w_mrg_x;
    assign w_rate_sat = (w_rate_x > BND_W'(RATE_MAX)) ? RATE_MAX : w_rate_x[RATE_W-1:0];
    assign w_lo_sat   = (w_lo > BND_W'(RATE_MAX)) ? RATE_MAX : w_lo[RATE_W-1:0];
    assign w_hi_sat   = (w_hi > BND_W'(HIGH_MAX)) ? HIGH_MAX : w_hi[HIGH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_scale  <= RST_VOLUME_SCALE;
            r_cfg_min    <= RST_MIN_MEASURE_TIME;
            r_cfg_sigma  <= RST_SIGMA_MULTIPLIER;
            r_held_rate  <= '0;
            r_held_low   <= '0;
            r_held_high  <= '0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_valid  <= 1'b0;
            r_go         <= 1'b0;
        end else begin
            r_div_start  <= w_div_go;
            r_sqrt_start <= w_in_acc && w_go;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOLUME_SCALE:     r_cfg_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_MIN_MEASURE_TIME: r_cfg_min   <= i_cfg_data[MINT_W-1:0];
                    CFG_SIGMA_MULTIPLIER: r_cfg_sigma <= i_cfg_data[SIGMA_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_count   <= COUNT_BITS'(i_in.pulse_count);
                        r_secs    <= i_in.measure_seconds;
                        r_go      <= w_go;
                        r_div_num <= NUM_W'(i_in.total_seconds);
                        r_div_den <= DEN_W'(SECS_PER_MIN);
                        r_state   <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (w_div_rsp.done) begin
                        r_div_num <= w_div_rsp.quot;
                        r_div_den <= DEN_W'(MIN_PER_HOUR);
                        r_state   <= S_HR;
                    end
                end
                S_HR: begin
                    if (w_div_rsp.done) begin
                        r_hours   <= w_div_rsp.quot[HOURS_W-1:0];
                        r_minutes <= w_div_rsp.rem[MINUTES_W-1:0];
                        if (r_go) begin
                            r_div_num <= NUM_W'(r_cfg_scale) * NUM_W'(r_count);
                            r_div_den <= r_secs;
                            r_state   <= S_RATE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RATE: begin
                    if (w_div_rsp.done) begin
                        r_rate  <= w_div_rsp.quot;
                        r_state <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (w_sqrt_idle) begin
                        r_div_num <= NUM_W'(r_cfg_scale) * NUM_W'(w_sqrt_rsp.root);
                        r_state   <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (w_div_rsp.done) begin
                        r_margin <= MRG_W'(r_cfg_sigma)
                                    * MRG_W'(w_div_rsp.quot[NUM_W-1:SQRT_FRAC_BITS]);
                        r_state  <= S_BND;
                    end
                end
                S_BND: begin
                    r_held_rate <= w_rate_sat;
                    r_held_low  <= w_lo_sat;
                    r_held_high <= w_hi_sat;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_rate    <= r_held_rate;
                        r_out_low     <= r_held_low;
                        r_out_high    <= r_held_high;
                        r_out_hours   <= r_hours;
                        r_out_minutes <= r_minutes;
                        r_out_fresh   <= r_go;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.rate        = r_out_rate;
    assign o_out.rate_low    = r_out_low;
    assign o_out.rate_high   = r_out_high;
    assign o_out.run_hours   = r_out_hours;
    assign o_out.run_minutes = r_out_minutes;
    assign o_out.fresh       = r_out_fresh;

    a_low_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_low <= r_out_rate)
        else $error("lower bound above rate");

    a_rate_below_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> HIGH_W'(r_out_rate) <= r_out_high)
        else $error("rate above upper bound");

    a_minutes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_minutes < MINUTES_W'(MIN_PER_HOUR))
        else $error("minutes out of range");

endmodule
